// File: rtl/tcf_pkg.sv
// ---------------------------------------------------------------------------
// Tilt complementary filter package
// Shared widths, register indexes, the state encoding and the CORDIC angle table.
// ---------------------------------------------------------------------------
package tcf_pkg;

    // Field widths
    localparam int RAW_W    = 16;
    localparam int TIME_W   = 32;
    localparam int TILT_W   = 18;
    localparam int ACCA_W   = 17;
    localparam int RATE_W   = 17;
    localparam int WGT_W    = 17;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAU    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

    // Divider geometry: 42-bit dividend, 21-bit divisor, one bit per cycle
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 21;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd41;

    // Controller states, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CORD  = 10'b00_0000_0010,
        S_RDIV  = 10'b00_0000_0100,
        S_WDIV  = 10'b00_0000_1000,
        S_WEND  = 10'b00_0001_0000,
        S_PMUL  = 10'b00_0010_0000,
        S_SLOAD = 10'b00_0100_0000,
        S_SDIV  = 10'b00_1000_0000,
        S_BMUL  = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tcf_in_if.sv
// ---------------------------------------------------------------------------
// Tilt filter sample channel
// Valid/ready channel carrying one command or sensor sample per beat.
// ---------------------------------------------------------------------------
interface tcf_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [tcf_pkg::RAW_W-1:0]  accel_x;
    logic signed [tcf_pkg::RAW_W-1:0]  accel_z;
    logic signed [tcf_pkg::RAW_W-1:0]  gyro_y;
    logic        [tcf_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, command, accel_x, accel_z, gyro_y, time_ms, input ready);
    modport sink   (input valid, command, accel_x, accel_z, gyro_y, time_ms, output ready);
endinterface

// File: rtl/tcf_out_if.sv
// ---------------------------------------------------------------------------
// Tilt filter result channel
// Valid/ready channel carrying one filter result per beat.
// ---------------------------------------------------------------------------
interface tcf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tcf_pkg::TILT_W-1:0] tilt_angle;
    logic        [tcf_pkg::ACCA_W-1:0] accel_angle;
    logic signed [tcf_pkg::RATE_W-1:0] gyro_rate;
    logic        [tcf_pkg::WGT_W-1:0]  blend_weight;

    modport source (output valid, tilt_angle, accel_angle, gyro_rate, blend_weight, input ready);
    modport sink   (input valid, tilt_angle, accel_angle, gyro_rate, blend_weight, output ready);
endinterface

// File: rtl/tilt_complementary_filter.sv
// Timing: a sample runs the CORDIC, then the one-bit-per-cycle divider up to three times
//   (rate, weight, gyro step) and the serial blend multiplier.
// A seeding sample skips the blend; a zero weight denominator skips the weight divide.
// A new sample is taken only in idle, once the last result is posted; a restart beat gives no result.
// Reset (synchronous, active low): registers to defaults, filter needs seeding, last time 0.
// ---------------------------------------------------------------------------
// Tilt complementary filter
// CORDIC tilt, gyro rate scaling, blend weight and filtered angle, digit serial.
// ---------------------------------------------------------------------------
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcf_pkg::CFG_W-1:0]         i_cfg_data,
    tcf_in_if.sink                            i_in,
    tcf_out_if.source                         o_out
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] C_LAST = CW'(CORDIC_STEPS - 1);

    // Configuration registers
    logic        [15:0] r_tau;
    logic signed [15:0] r_bias;
    logic signed [17:0] r_offset;

    // Control and state
    tcf_pkg::t_state    r_state;
    logic               r_seed;
    logic        [31:0] r_last;
    logic signed [31:0] r_filt;

    // Sample payload
    logic signed [15:0] r_gy;
    logic        [19:0] r_dt;
    logic               r_zero;
    logic signed [26:0] r_cx, r_cy, r_ca;
    logic      [CW-1:0] r_ci;
    logic        [16:0] r_acc;
    logic signed [16:0] r_rate;
    logic        [16:0] r_w;
    logic signed [43:0] r_prod;

    // Divider
    logic [tcf_pkg::DIV_NUM_W-1:0] r_dnum, r_dq;
    logic [tcf_pkg::DIV_DEN_W-1:0] r_drem, r_dden;
    logic [tcf_pkg::DIV_CNT_W-1:0] r_dcnt;

    // Serial multiplier
    logic signed [55:0] r_mcand, r_macc;
    logic        [16:0] r_mplier;
    logic         [4:0] r_mcnt;

    // Result register
    logic               r_ov;
    logic signed [17:0] r_o_tilt;
    logic        [16:0] r_o_acc;
    logic signed [16:0] r_o_rate;
    logic        [16:0] r_o_w;

    logic in_acc, out_take, fin_post;
    assign i_in.ready = (r_state == tcf_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_take   = r_ov && o_out.ready;
    assign fin_post   = (r_state == tcf_pkg::S_FIN) && (!r_ov || o_out.ready);

    assign o_out.valid        = r_ov;
    assign o_out.tilt_angle   = r_o_tilt;
    assign o_out.accel_angle  = r_o_acc;
    assign o_out.gyro_rate    = r_o_rate;
    assign o_out.blend_weight = r_o_w;

    // Combinational datapath
    logic        [31:0] tdiff;
    logic        [19:0] dt_in;
    logic signed [26:0] xs, ys, ix, iy, ia;
    logic signed [26:0] shx, shy, at, n_cx, n_cy, n_ca, af;
    logic        [16:0] acc_c;
    logic signed [16:0] gy17;
    logic        [16:0] gmag;
    logic        [21:0] rem2;
    logic               ge;
    logic [tcf_pkg::DIV_DEN_W-1:0] n_drem;
    logic [tcf_pkg::DIV_NUM_W-1:0] n_dq;
    logic signed [18:0] rq, rsum;
    logic signed [16:0] rate_c;
    logic        [20:0] den;
    logic        [32:0] wnum;
    logic signed [37:0] pmul;
    logic        [43:0] pmag;
    logic signed [36:0] step;
    logic signed [37:0] ssum;
    logic signed [25:0] acc_s;
    logic signed [38:0] diff;
    logic signed [55:0] n_macc;
    logic signed [57:0] total;
    logic signed [41:0] blend;
    logic signed [31:0] filt_c;
    logic signed [32:0] t1;
    logic signed [25:0] t3;
    logic signed [17:0] tilt_c;

    always_comb begin
        // elapsed time, saturated
        tdiff = i_in.time_ms - r_last;
        dt_in = (tdiff > 32'd1048575) ? 20'hFFFFF : tdiff[19:0];

        // CORDIC pre-rotation into the right half plane
        xs = {{3{i_in.accel_z[15]}}, i_in.accel_z, 8'h00};
        ys = {{3{i_in.accel_x[15]}}, i_in.accel_x, 8'h00};
        ix = xs;
        iy = ys;
        ia = '0;
        if (xs[26]) begin
            if (!ys[26]) begin
                ix = ys;
                iy = -xs;
                ia = 27'sd5898240;
            end else begin
                ix = -ys;
                iy = xs;
                ia = -27'sd5898240;
            end
        end

        // one CORDIC micro-rotation
        shx = r_cx >>> r_ci;
        shy = r_cy >>> r_ci;
        at  = $signed({5'b0, tcf_pkg::atan_entry(5'(r_ci))});
        if (!r_cy[26]) begin
            n_cx = r_cx + shy;
            n_cy = r_cy - shx;
            n_ca = r_ca + at;
        end else begin
            n_cx = r_cx - shy;
            n_cy = r_cy + shx;
            n_ca = r_ca - at;
        end
        // add 180 degrees and half an output step
        af = n_ca + 27'sd11796608;
        if (af[26]) begin
            acc_c = 17'd0;
        end else if (af > 27'sd23592960) begin
            acc_c = 17'd92160;
        end else begin
            acc_c = af[24:8];
        end
        if (r_zero) begin
            acc_c = 17'd46080;
        end

        // gyro magnitude for the divide by 131
        gy17 = 17'(r_gy);
        gmag = gy17[16] ? 17'(-gy17) : 17'(gy17);

        // one restoring divider step
        rem2   = {r_drem, r_dnum[tcf_pkg::DIV_NUM_W-1]};
        ge     = (rem2 >= {1'b0, r_dden});
        n_drem = ge ? 21'(rem2 - {1'b0, r_dden}) : rem2[20:0];
        n_dq   = {r_dq[tcf_pkg::DIV_NUM_W-2:0], ge};

        // gyro rate: negate, add bias, saturate
        rq = (!r_gy[15] && (r_gy != 16'sd0)) ? -$signed({2'b0, n_dq[16:0]})
                                               : $signed({2'b0, n_dq[16:0]});
        rsum = rq + 19'(r_bias);
        if (rsum < -19'sd65536) begin
            rate_c = -17'sd65536;
        end else if (rsum > 19'sd65535) begin
            rate_c = 17'sd65535;
        end else begin
            rate_c = rsum[16:0];
        end

        // weight divide operands
        den  = {5'b0, r_tau} + {1'b0, r_dt};
        wnum = {1'b0, r_tau, 16'h0000} + {13'b0, den[20:1]};

        // gyro step product and magnitude
        pmul = r_rate * $signed({1'b0, r_dt});
        pmag = r_prod[43] ? 44'(-r_prod) : 44'(r_prod);

        // blend difference: filt + step - accel*256
        step  = r_prod[43] ? -$signed({1'b0, n_dq[35:0]}) : $signed({1'b0, n_dq[35:0]});
        acc_s = $signed({1'b0, r_acc, 8'h00});
        ssum  = 38'(r_filt) + 38'(step);
        diff  = 39'(ssum) - 39'(acc_s);

        // serial multiply step and final blend
        n_macc = r_mplier[0] ? (r_macc + r_mcand) : r_macc;
        total  = 58'(n_macc) + 58'($signed({1'b0, r_acc, 24'h000000})) + 58'sd32768;
        blend  = total[57:16];
        if (blend > 42'sd2147483647) begin
            filt_c = 32'sh7FFFFFFF;
        end else if (blend < -42'sd2147483648) begin
            filt_c = 32'sh80000000;
        end else begin
            filt_c = blend[31:0];
        end

        // output angle: round, offset, saturate
        t1 = 33'(r_filt) + 33'sd128;
        t3 = 26'(t1 >>> 8) + 26'(r_offset);
        if (t3 > 26'sd131071) begin
            tilt_c = 18'sd131071;
        end else if (t3 < -26'sd131072) begin
            tilt_c = -18'sd131072;
        end else begin
            tilt_c = t3[17:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau    <= 16'd3000;
            r_bias   <= 16'sd205;
            r_offset <= -18'sd50790;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcf_pkg::REG_TAU:    r_tau    <= i_cfg_data[15:0];
                tcf_pkg::REG_BIAS:   r_bias   <= $signed(i_cfg_data[15:0]);
                tcf_pkg::REG_OFFSET: r_offset <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Controller and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::S_IDLE;
            r_seed  <= 1'b1;
            r_last  <= '0;
            r_filt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // post a new result or free the result register
            if (fin_post) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                tcf_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.command) begin
                            r_seed <= 1'b1;
                            r_last <= '0;
                        end else begin
                            r_last  <= i_in.time_ms;
                            r_state <= tcf_pkg::S_CORD;
                        end
                    end
                end
                tcf_pkg::S_CORD: begin
                    if (r_ci == C_LAST) begin
                        r_state <= tcf_pkg::S_RDIV;
                    end
                end
                tcf_pkg::S_RDIV: begin
                    if (r_dcnt == tcf_pkg::DIV_LAST) begin
                        r_state <= (den == 21'd0) ? tcf_pkg::S_WEND : tcf_pkg::S_WDIV;
                    end
                end
                tcf_pkg::S_WDIV: begin
                    if (r_dcnt == tcf_pkg::DIV_LAST) begin
                        r_state <= tcf_pkg::S_WEND;
                    end
                end
                tcf_pkg::S_WEND: begin
                    if (r_seed) begin
                        r_seed  <= 1'b0;
                        r_filt  <= $signed({7'b0, r_acc, 8'h00});
                        r_state <= tcf_pkg::S_FIN;
                    end else begin
                        r_state <= tcf_pkg::S_PMUL;
                    end
                end
                tcf_pkg::S_PMUL:  r_state <= tcf_pkg::S_SLOAD;
                tcf_pkg::S_SLOAD: r_state <= tcf_pkg::S_SDIV;
                tcf_pkg::S_SDIV: begin
                    if (r_dcnt == tcf_pkg::DIV_LAST) begin
                        r_state <= tcf_pkg::S_BMUL;
                    end
                end
                tcf_pkg::S_BMUL: begin
                    if (r_mcnt == 5'd16) begin
                        r_filt  <= filt_c;
                        r_state <= tcf_pkg::S_FIN;
                    end
                end
                tcf_pkg::S_FIN: begin
                    if (fin_post) begin
                        r_state <= tcf_pkg::S_IDLE;
                    end
                end
                default: r_state <= tcf_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tcf_pkg::S_IDLE: begin
                // capture sample and start the CORDIC
                r_gy   <= i_in.gyro_y;
                r_dt   <= dt_in;
                r_zero <= (i_in.accel_x == 16'sd0) && (i_in.accel_z == 16'sd0);
                r_cx   <= ix;
                r_cy   <= iy;
                r_ca   <= ia;
                r_ci   <= '0;
            end
            tcf_pkg::S_CORD: begin
                r_cx <= n_cx;
                r_cy <= n_cy;
                r_ca <= n_ca;
                r_ci <= r_ci + CW'(1);
                if (r_ci == C_LAST) begin
                    // load the divide by 131
                    r_acc  <= acc_c;
                    r_dnum <= {17'b0, gmag, 8'h00} + 42'd65;
                    r_dden <= 21'd131;
                    r_drem <= '0;
                    r_dq   <= '0;
                    r_dcnt <= '0;
                end
            end
            tcf_pkg::S_RDIV, tcf_pkg::S_WDIV, tcf_pkg::S_SDIV: begin
                if (r_dcnt == tcf_pkg::DIV_LAST) begin
                    if (r_state == tcf_pkg::S_RDIV) begin
                        // load the weight divide
                        r_rate <= rate_c;
                        r_w    <= 17'd65536;
                        r_dnum <= {9'b0, wnum};
                        r_dden <= den;
                        r_drem <= '0;
                        r_dq   <= '0;
                        r_dcnt <= '0;
                    end else if (r_state == tcf_pkg::S_WDIV) begin
                        r_w <= n_dq[16:0];
                    end else begin
                        // load the blend multiply
                        r_mcand  <= 56'(diff);
                        r_mplier <= r_w;
                        r_macc   <= '0;
                        r_mcnt   <= '0;
                    end
                end else begin
                    // advance one quotient bit
                    r_dnum <= {r_dnum[tcf_pkg::DIV_NUM_W-2:0], 1'b0};
                    r_drem <= n_drem;
                    r_dq   <= n_dq;
                    r_dcnt <= r_dcnt + 6'd1;
                end
            end
            tcf_pkg::S_PMUL: begin
                r_prod <= {pmul[37], pmul, 5'b00000};
            end
            tcf_pkg::S_SLOAD: begin
                // load the divide by 125
                r_dnum <= pmag[41:0] + 42'd62;
                r_dden <= 21'd125;
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= '0;
            end
            tcf_pkg::S_BMUL: begin
                r_macc   <= n_macc;
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_mcnt   <= r_mcnt + 5'd1;
            end
            tcf_pkg::S_FIN: begin
                if (fin_post) begin
                    r_o_tilt <= tilt_c;
                    r_o_acc  <= r_acc;
                    r_o_rate <= r_rate;
                    r_o_w    <= r_w;
                end
            end
            default: ;
        endcase
    end

    // Assertions
    a_restart_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.command) |=> (r_seed && (r_last == 32'd0)))
        else $error("restart did not arm seeding");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcf_pkg::S_RDIV || r_state == tcf_pkg::S_WDIV ||
         r_state == tcf_pkg::S_SDIV) |-> (r_dcnt <= tcf_pkg::DIV_LAST))
        else $error("divider counter overrun");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_acc <= 17'd92160))
        else $error("accel angle out of range");

    a_wgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_w <= 17'd65536))
        else $error("blend weight out of range");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcf_pkg::S_FIN && (!r_ov || o_out.ready)) |=>
            (r_ov && r_state == tcf_pkg::S_IDLE))
        else $error("result not posted");

endmodule
